// ===== design/ljf_pkg.sv =====
// Shared types, constants and arithmetic helpers of the Lennard-Jones pair force block.
`timescale 1ns / 1ps
package ljf_pkg;

   // Default store depth.
   localparam int MAX_PARTICLES_DEF = 64;

   // Fixed field widths.
   localparam int COORD_W = 24;
   localparam int CUT_W   = 32;
   localparam int FORCE_W = 48;
   localparam int PART_W  = 6;
   localparam int DIST_W  = 26;
   localparam int ABS_W   = 25;
   localparam int R2_W    = 50;
   localparam int WORD_W  = 64;

   // Scale factors of the force and energy terms.
   localparam int LJ_FORCE_K  = 24;
   localparam int LJ_ENERGY_K = 4;

   // Saturation bounds of a 48-bit signed accumulator.
   localparam logic [FORCE_W-1:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [FORCE_W-1:0] S48_MIN = 48'h8000_0000_0000;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SIGMA   = 2'd0,
      CSR_EPSILON = 2'd1,
      CSR_BOX     = 2'd2,
      CSR_CUTOFF  = 2'd3
   } csr_index_type;

   // Input item.
   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic               last;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [PART_W-1:0]         particle;
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic signed [FORCE_W-1:0] force_z;
      logic signed [FORCE_W-1:0] energy;
      logic                      done_res;
   } rsp_type;

   // Post-shift applied by the multiplier.
   typedef enum logic [1:0] {
      MSH_NONE = 2'd0,
      MSH_16   = 2'd1,
      MSH_32   = 2'd2
   } mul_shift_type;

   // Command to the shared multiplier.
   typedef struct packed {
      logic                start;
      mul_shift_type       shift;
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
   } mul_cmd_type;

   // Command to the shared divider.
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] num;
      logic [R2_W-1:0]   den;
   } div_cmd_type;

   // Add a signed-magnitude term to a 48-bit accumulator, clamping term and sum.
   function automatic logic [FORCE_W-1:0] sat_add(input logic [FORCE_W-1:0] acc,
                                                  input logic [WORD_W-1:0] mag,
                                                  input logic neg);
      logic [FORCE_W-2:0] m;
      logic [FORCE_W:0]   s;
      m = (mag[WORD_W-1:FORCE_W-1] != '0) ? S48_MAX[FORCE_W-2:0] : mag[FORCE_W-2:0];
      if (neg) begin
         s = {acc[FORCE_W-1], acc} - {2'b00, m};
      end else begin
         s = {acc[FORCE_W-1], acc} + {2'b00, m};
      end
      if (s[FORCE_W] != s[FORCE_W-1]) begin
         return s[FORCE_W] ? S48_MIN : S48_MAX;
      end
      return s[FORCE_W-1:0];
   endfunction

   // Minimum-image difference a - b for a periodic edge of len.
   function automatic logic [DIST_W-1:0] min_image(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b,
                                                   input logic [COORD_W-1:0] len);
      logic [DIST_W-1:0] r;
      logic [DIST_W:0]   r2x;
      logic [DIST_W:0]   lpos;
      logic [DIST_W:0]   lneg;
      r    = {2'b00, a} - {2'b00, b};
      r2x  = {r, 1'b0};
      lpos = {3'b000, len};
      lneg = '0 - lpos;
      if ($signed(r2x) < $signed(lneg)) begin
         r = r + {2'b00, len};
      end else if ($signed(r2x) > $signed(lpos)) begin
         r = r - {2'b00, len};
      end
      return r;
   endfunction

endpackage

// ===== design/ljf_mul.sv =====
// Shared 64x64 multiplier built from one 32x32 multiplier over four partial-product steps.
`timescale 1ns / 1ps
module ljf_mul
   import ljf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mul_cmd_type       cmd,
   output logic              done,
   output logic [WORD_W-1:0] result
);

   localparam int HALF_W    = WORD_W / 2;
   localparam int MUL_STEPS = 4;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [WORD_W-1:0]   b_ff, b_in;
   mul_shift_type       shift_ff, shift_in;
   logic [WORD_W-1:0]   pp_ff, pp_in;
   logic [1:0]          off_ff, off_in;
   logic [2*WORD_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]   a_part;
   logic [HALF_W-1:0]   b_part;
   logic [2*WORD_W-1:0] pp_wide;

   // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1.
   always_comb begin
      a_part = cnt_ff[1] ? a_ff[WORD_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_part = cnt_ff[0] ? b_ff[WORD_W-1:HALF_W] : b_ff[HALF_W-1:0];
      case (off_ff)
         2'd0:    pp_wide = {{WORD_W{1'b0}}, pp_ff};
         2'd1:    pp_wide = {{HALF_W{1'b0}}, pp_ff, {HALF_W{1'b0}}};
         2'd2:    pp_wide = {pp_ff, {WORD_W{1'b0}}};
         default: pp_wide = '0;
      endcase
   end

   // Step sequencing and accumulation.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      shift_in = shift_ff;
      pp_in    = pp_ff;
      off_in   = off_ff;
      acc_in   = acc_ff;
      if (busy_ff) begin
         if (cnt_ff < 3'(MUL_STEPS)) begin
            pp_in  = a_part * b_part;
            off_in = 2'({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]});
         end
         if (cnt_ff != 3'd0) begin
            acc_in = acc_ff + pp_wide;
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'(MUL_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         a_in     = cmd.a;
         b_in     = cmd.b;
         shift_in = cmd.shift;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      shift_ff <= shift_in;
      pp_ff    <= pp_in;
      off_ff   <= off_in;
      acc_ff   <= acc_in;
   end

   // Post-shift with saturation at the all-ones word.
   always_comb begin
      case (shift_ff)
         MSH_NONE: result = acc_ff[WORD_W-1:0];
         MSH_16:   result = (acc_ff[2*WORD_W-1:WORD_W+16] != '0) ? '1
                                                              : acc_ff[WORD_W+15:16];
         MSH_32:   result = (acc_ff[2*WORD_W-1:WORD_W+32] != '0) ? '1
                                                              : acc_ff[WORD_W+31:32];
         default:  result = acc_ff[WORD_W-1:0];
      endcase
   end

   assign done = done_ff;

endmodule

// ===== design/ljf_div.sv =====
// Shared restoring divider: floor(num * 2^32 / den), one quotient bit per cycle.
`timescale 1ns / 1ps
module ljf_div
   import ljf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       cmd,
   output logic              done,
   output logic [WORD_W-1:0] quotient
);

   localparam int HALF_W    = WORD_W / 2;
   localparam int DIV_STEPS = WORD_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [R2_W-1:0]   den_ff, den_in;
   logic [R2_W-1:0]   rem_ff, rem_in;
   logic [HALF_W-1:0] lo_ff, lo_in;
   logic [WORD_W-1:0] q_ff, q_in;
   logic [R2_W:0]     trial;
   logic              ge;

   always_comb begin
      trial = {rem_ff, lo_ff[HALF_W-1]};
      ge    = (trial >= {1'b0, den_ff});
   end

   // One restoring step per cycle; an oversized numerator saturates at once.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      if (busy_ff) begin
         rem_in = ge ? R2_W'(trial - {1'b0, den_ff}) : trial[R2_W-1:0];
         lo_in  = {lo_ff[HALF_W-2:0], 1'b0};
         q_in   = {q_ff[WORD_W-2:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         den_in = cmd.den;
         cnt_in = '0;
         if ({{(R2_W-HALF_W){1'b0}}, cmd.num[WORD_W-1:HALF_W]} >= cmd.den) begin
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            rem_in  = {{(R2_W-HALF_W){1'b0}}, cmd.num[WORD_W-1:HALF_W]};
            lo_in   = cmd.num[HALF_W-1:0];
            q_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== design/lj_all_pairs_force_core.sv =====
// Usage: the request channel (req_valid, req_stall, req_data) loads one particle
// position per transfer into the coordinate store; req_data.last closes the set.
// Positions beyond MAX_PARTICLES are dropped. While a set is being evaluated the
// block holds req_stall high. It then sums Lennard-Jones forces over all pairs
// i < j with minimum-image folding and a squared cutoff, and returns one result
// per particle on the response channel, in load order; the final one carries
// the total energy and done_res. Loading accepts one item per cycle. The
// evaluation clears the accumulators, then works through the pairs on the shared
// four-step multiplier and the 64-step divider: a pair outside the cutoff needs
// only its three squares, one inside it 12 products and two quotients. Each
// result is read from the store, loaded into the output register and held until
// its transfer.
// rsp_valid holds with a stable payload while rsp_stall is high. Configuration
// writes on the csr_ port are always ready and are meant for idle periods.
// Synchronous reset restores register defaults, empties the store and returns
// to loading; no clearing pass is needed.
`timescale 1ns / 1ps
module lj_all_pairs_force_core
   import ljf_pkg::*;
#(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [CUT_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } coord_type;

   typedef struct packed {
      logic [FORCE_W-1:0] fx;
      logic [FORCE_W-1:0] fy;
      logic [FORCE_W-1:0] fz;
   } facc_type;

   typedef enum logic [23:0] {
      ST_LOAD     = 24'h000001,
      ST_CLEAR    = 24'h000002,
      ST_RDI      = 24'h000004,
      ST_RDJ      = 24'h000008,
      ST_DIFF     = 24'h000010,
      ST_SQ       = 24'h000020,
      ST_CMP      = 24'h000040,
      ST_SIG      = 24'h000080,
      ST_DIV1     = 24'h000100,
      ST_P1       = 24'h000200,
      ST_P2       = 24'h000400,
      ST_P3       = 24'h000800,
      ST_EN       = 24'h001000,
      ST_W        = 24'h002000,
      ST_DIV2     = 24'h004000,
      ST_FRC      = 24'h008000,
      ST_AI_RD    = 24'h010000,
      ST_AI_WR    = 24'h020000,
      ST_AJ_RD    = 24'h040000,
      ST_AJ_WR    = 24'h080000,
      ST_NEXT     = 24'h100000,
      ST_OUT_RD   = 24'h200000,
      ST_OUT_LD   = 24'h400000,
      ST_OUT_WAIT = 24'h800000
   } state_type;

   // Configuration registers.
   logic [COORD_W-1:0] sigma_ff, epsilon_ff, box_ff;
   logic [CUT_W-1:0]   cutoff_ff;

   // Control state.
   state_type          state_ff, state_in;
   logic               go_ff, go_in;
   logic               again;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FORCE_W-1:0] energy_ff, energy_in;

   // Sequencer counters and pair datapath.
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [1:0]         ax_ff, ax_in;
   coord_type          ci_ff, ci_in;
   logic [ABS_W-1:0]   ad_ff [3];
   logic [ABS_W-1:0]   ad_in [3];
   logic               dn_ff [3];
   logic               dn_in [3];
   logic [WORD_W-1:0]  term_ff [3];
   logic [WORD_W-1:0]  term_in [3];
   logic [R2_W-1:0]    r2_ff, r2_in;
   logic [WORD_W-1:0]  num_ff, num_in;
   logic [WORD_W-1:0]  s2_ff, s2_in;
   logic [WORD_W-1:0]  t_ff, t_in;
   logic [WORD_W-1:0]  s6_ff, s6_in;
   logic [WORD_W-1:0]  s12_ff, s12_in;
   logic [WORD_W-1:0]  fr_ff, fr_in;
   logic               fneg_ff, fneg_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Memories.
   coord_type          coord_mem [MAX_PARTICLES];
   coord_type          coord_rd_ff;
   logic               coord_we;
   logic [IDX_W-1:0]   coord_raddr;
   facc_type           facc_mem [MAX_PARTICLES];
   facc_type           facc_rd_ff;
   logic               facc_we;
   logic [IDX_W-1:0]   facc_waddr;
   facc_type           facc_wdata;
   logic [IDX_W-1:0]   facc_raddr;

   // Shared units.
   mul_cmd_type        mul_cmd;
   logic               mul_done;
   logic [WORD_W-1:0]  mul_res;
   div_cmd_type        div_cmd;
   logic               div_done;
   logic [WORD_W-1:0]  div_q;

   // Derived terms.
   logic               accept;
   logic               eneg;
   logic [WORD_W-1:0]  emag;
   logic [WORD_W-1:0]  s12x2;
   logic               fneg;
   logic [WORD_W-1:0]  fmag;
   logic [28:0]        eps24;
   logic [25:0]        eps4;
   logic [DIST_W-1:0]  dd [3];
   logic               neg_ax [3];

   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Energy and force magnitudes from the current s6 and s12.
   always_comb begin
      eneg  = (s12_ff < s6_ff);
      emag  = eneg ? (s6_ff - s12_ff) : (s12_ff - s6_ff);
      s12x2 = s12_ff[WORD_W-1] ? '1 : {s12_ff[WORD_W-2:0], 1'b0};
      fneg  = (s12x2 < s6_ff);
      fmag  = fneg ? (s6_ff - s12x2) : (s12x2 - s6_ff);
      eps24 = 29'(epsilon_ff) * 29'(LJ_FORCE_K);
      eps4  = 26'(epsilon_ff) * 26'(LJ_ENERGY_K);
      dd[0] = min_image(ci_ff.x, coord_rd_ff.x, box_ff);
      dd[1] = min_image(ci_ff.y, coord_rd_ff.y, box_ff);
      dd[2] = min_image(ci_ff.z, coord_rd_ff.z, box_ff);
      for (int a = 0; a < 3; a++) begin
         neg_ax[a] = fneg_ff ^ dn_ff[a];
      end
   end

   // Operand selection for the shared multiplier and divider.
   always_comb begin
      mul_cmd.start = 1'b0;
      mul_cmd.shift = MSH_32;
      mul_cmd.a     = s2_ff;
      mul_cmd.b     = s2_ff;
      div_cmd.start = 1'b0;
      div_cmd.num   = num_ff;
      div_cmd.den   = r2_ff;
      case (state_ff)
         ST_SQ: begin
            mul_cmd.start = go_ff;
            mul_cmd.shift = MSH_NONE;
            mul_cmd.a     = WORD_W'(ad_ff[ax_ff]);
            mul_cmd.b     = WORD_W'(ad_ff[ax_ff]);
         end
         ST_SIG: begin
            mul_cmd.start = go_ff;
            mul_cmd.shift = MSH_NONE;
            mul_cmd.a     = WORD_W'(sigma_ff);
            mul_cmd.b     = WORD_W'(sigma_ff);
         end
         ST_P1: begin
            mul_cmd.start = go_ff;
         end
         ST_P2: begin
            mul_cmd.start = go_ff;
            mul_cmd.a     = t_ff;
         end
         ST_P3: begin
            mul_cmd.start = go_ff;
            mul_cmd.a     = s6_ff;
            mul_cmd.b     = s6_ff;
         end
         ST_EN: begin
            mul_cmd.start = go_ff;
            mul_cmd.a     = emag;
            mul_cmd.b     = WORD_W'(eps4);
         end
         ST_W: begin
            mul_cmd.start = go_ff;
            mul_cmd.shift = MSH_16;
            mul_cmd.a     = fmag;
            mul_cmd.b     = WORD_W'(eps24);
         end
         ST_FRC: begin
            mul_cmd.start = go_ff;
            mul_cmd.a     = fr_ff;
            mul_cmd.b     = WORD_W'(ad_ff[ax_ff]);
         end
         ST_DIV1, ST_DIV2: begin
            div_cmd.start = go_ff;
         end
         default: begin
            mul_cmd.start = 1'b0;
         end
      endcase
   end

   // Sequencer: load, clear, pair loop, then result readout.
   always_comb begin
      state_in     = state_ff;
      again        = 1'b0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      energy_in    = energy_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ax_in        = ax_ff;
      ci_in        = ci_ff;
      ad_in        = ad_ff;
      dn_in        = dn_ff;
      term_in      = term_ff;
      r2_in        = r2_ff;
      num_in       = num_ff;
      s2_in        = s2_ff;
      t_in         = t_ff;
      s6_in        = s6_ff;
      s12_in       = s12_ff;
      fr_in        = fr_ff;
      fneg_in      = fneg_ff;
      rsp_data_in  = rsp_data_ff;
      coord_we     = 1'b0;
      coord_raddr  = i_ff[IDX_W-1:0];
      facc_we      = 1'b0;
      facc_waddr   = k_ff[IDX_W-1:0];
      facc_wdata   = '0;
      facc_raddr   = k_ff[IDX_W-1:0];
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (cnt_ff < CNT_W'(MAX_PARTICLES)) begin
                  coord_we = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
               end
               if (req_data.last) begin
                  n_in     = (cnt_ff < CNT_W'(MAX_PARTICLES)) ? CNT_W'(cnt_ff + 1'b1)
                                                                 : cnt_ff;
                  k_in     = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            facc_we   = 1'b1;
            energy_in = '0;
            if (CNT_W'(k_ff + 1'b1) == n_ff) begin
               i_in     = '0;
               j_in     = CNT_W'(1);
               k_in     = '0;
               state_in = (n_ff < CNT_W'(2)) ? ST_OUT_RD : ST_RDI;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_RDI: begin
            coord_raddr = i_ff[IDX_W-1:0];
            state_in    = ST_RDJ;
         end
         ST_RDJ: begin
            ci_in       = coord_rd_ff;
            coord_raddr = j_ff[IDX_W-1:0];
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            for (int a = 0; a < 3; a++) begin
               dn_in[a] = dd[a][DIST_W-1];
               ad_in[a] = dd[a][DIST_W-1] ? ABS_W'('0 - dd[a]) : dd[a][ABS_W-1:0];
            end
            r2_in    = '0;
            ax_in    = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (mul_done) begin
               r2_in = r2_ff + mul_res[R2_W-1:0];
               if (ax_ff == 2'd2) begin
                  state_in = ST_CMP;
               end else begin
                  ax_in = ax_ff + 2'd1;
                  again = 1'b1;
               end
            end
         end
         ST_CMP: begin
            if (r2_ff == '0 || r2_ff >= {2'b00, cutoff_ff, 16'h0000}) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_SIG;
            end
         end
         ST_SIG: begin
            if (mul_done) begin
               num_in   = mul_res;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               s2_in    = div_q;
               state_in = ST_P1;
            end
         end
         ST_P1: begin
            if (mul_done) begin
               t_in     = mul_res;
               state_in = ST_P2;
            end
         end
         ST_P2: begin
            if (mul_done) begin
               s6_in    = mul_res;
               state_in = ST_P3;
            end
         end
         ST_P3: begin
            if (mul_done) begin
               s12_in   = mul_res;
               state_in = ST_EN;
            end
         end
         ST_EN: begin
            if (mul_done) begin
               energy_in = sat_add(energy_ff, mul_res, eneg);
               state_in  = ST_W;
            end
         end
         ST_W: begin
            if (mul_done) begin
               num_in   = mul_res;
               fneg_in  = fneg;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               fr_in    = div_q;
               ax_in    = '0;
               state_in = ST_FRC;
            end
         end
         ST_FRC: begin
            if (mul_done) begin
               term_in[ax_ff] = mul_res;
               if (ax_ff == 2'd2) begin
                  state_in = ST_AI_RD;
               end else begin
                  ax_in = ax_ff + 2'd1;
                  again = 1'b1;
               end
            end
         end
         ST_AI_RD: begin
            facc_raddr = i_ff[IDX_W-1:0];
            state_in   = ST_AI_WR;
         end
         ST_AI_WR: begin
            facc_we       = 1'b1;
            facc_waddr    = i_ff[IDX_W-1:0];
            facc_wdata.fx = sat_add(facc_rd_ff.fx, term_ff[0], neg_ax[0]);
            facc_wdata.fy = sat_add(facc_rd_ff.fy, term_ff[1], neg_ax[1]);
            facc_wdata.fz = sat_add(facc_rd_ff.fz, term_ff[2], neg_ax[2]);
            state_in      = ST_AJ_RD;
         end
         ST_AJ_RD: begin
            facc_raddr = j_ff[IDX_W-1:0];
            state_in   = ST_AJ_WR;
         end
         ST_AJ_WR: begin
            facc_we       = 1'b1;
            facc_waddr    = j_ff[IDX_W-1:0];
            facc_wdata.fx = sat_add(facc_rd_ff.fx, term_ff[0], ~neg_ax[0]);
            facc_wdata.fy = sat_add(facc_rd_ff.fy, term_ff[1], ~neg_ax[1]);
            facc_wdata.fz = sat_add(facc_rd_ff.fz, term_ff[2], ~neg_ax[2]);
            state_in      = ST_NEXT;
         end
         ST_NEXT: begin
            if (CNT_W'(j_ff + 1'b1) < n_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = ST_RDI;
            end else if (({1'b0, i_ff} + (CNT_W+1)'(2)) < {1'b0, n_ff}) begin
               i_in     = i_ff + 1'b1;
               j_in     = CNT_W'(i_ff + CNT_W'(2));
               state_in = ST_RDI;
            end else begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD: begin
            facc_raddr = k_ff[IDX_W-1:0];
            state_in   = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in         = 1'b1;
            rsp_data_in.particle = PART_W'(k_ff);
            rsp_data_in.force_x  = facc_rd_ff.fx;
            rsp_data_in.force_y  = facc_rd_ff.fy;
            rsp_data_in.force_z  = facc_rd_ff.fz;
            rsp_data_in.done_res = (CNT_W'(k_ff + 1'b1) == n_ff);
            rsp_data_in.energy   = (CNT_W'(k_ff + 1'b1) == n_ff) ? energy_ff : '0;
            state_in             = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (CNT_W'(k_ff + 1'b1) == n_ff) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      go_in = (state_in != state_ff) | again;
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         go_ff        <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         sigma_ff     <= 24'd65536;
         epsilon_ff   <= 24'd65536;
         box_ff       <= 24'd655360;
         cutoff_ff    <= 32'd409600;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SIGMA:   sigma_ff   <= csr_wdata[COORD_W-1:0];
               CSR_EPSILON: epsilon_ff <= csr_wdata[COORD_W-1:0];
               CSR_BOX:     box_ff     <= csr_wdata[COORD_W-1:0];
               CSR_CUTOFF:  cutoff_ff  <= csr_wdata;
               default:     cutoff_ff  <= cutoff_ff;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      ax_ff       <= ax_in;
      ci_ff       <= ci_in;
      ad_ff       <= ad_in;
      dn_ff       <= dn_in;
      term_ff     <= term_in;
      r2_ff       <= r2_in;
      num_ff      <= num_in;
      s2_ff       <= s2_in;
      t_ff        <= t_in;
      s6_ff       <= s6_in;
      s12_ff      <= s12_in;
      fr_ff       <= fr_in;
      fneg_ff     <= fneg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Coordinate store: written on load, read one entry per cycle.
   always_ff @(posedge clock) begin
      if (coord_we) begin
         coord_mem[cnt_ff[IDX_W-1:0]] <= '{x: req_data.pos_x, y: req_data.pos_y,
                                           z: req_data.pos_z};
      end
      coord_rd_ff <= coord_mem[coord_raddr];
   end

   // Force accumulator store: read-modify-write through a registered read.
   always_ff @(posedge clock) begin
      if (facc_we) begin
         facc_mem[facc_waddr] <= facc_wdata;
      end
      facc_rd_ff <= facc_mem[facc_raddr];
   end

   ljf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mul_cmd),
      .done   (mul_done),
      .result (mul_res)
   );

   ljf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

`ifndef SYNTHESIS
   // A result is shown only while the readout waits for its transfer.
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT_WAIT)
      else $error("result valid outside readout");

   // The fill count never passes the store depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_PARTICLES))
      else $error("fill count beyond store depth");

   // Every evaluated pair has i < j < n.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIFF |-> (j_ff > i_ff) && (j_ff < n_ff))
      else $error("pair indexes out of order");

   // The final transfer returns the block to loading with an empty store.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.done_res |=> state_ff == ST_LOAD && cnt_ff == '0)
      else $error("run did not end after final result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the Lennard-Jones all-pairs force core.
`timescale 1ns / 1ps
module testbench;
   import ljf_pkg::*;

   localparam logic [63:0] SAT48 = 64'h7FFF_FFFF_FFFF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = CSR_SIGMA;
   logic [CUT_W-1:0] csr_wdata = '0;

   lj_all_pairs_force_core DUT (.*);

   always #5 clock = ~clock;

   // Shadow copy of the configuration and the particle set.
   logic [63:0] lj_sigma, lj_eps, lj_box, lj_cut;
   logic [63:0] pos_x_q[$], pos_y_q[$], pos_z_q[$];
   longint      frc_x[MAX_PARTICLES_DEF], frc_y[MAX_PARTICLES_DEF], frc_z[MAX_PARTICLES_DEF];
   longint      energy_sum;
   rsp_type     force_results_q[$];

   int  mismatches = 0;
   int  results_seen = 0;
   int  sets_done = 0;
   int  items_sent = 0;
   bit  quiet = 1'b0;

   // floor(a*b / 2^sh), saturating at 2^64-1.
   function automatic logic [63:0] mul_scaled(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> sh;
      if (p[127:64] != '0) return '1;
      return p[63:0];
   endfunction

   // floor(num * 2^32 / den), saturating.
   function automatic logic [63:0] div_scaled(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      if ((num >> 32) >= den) return '1;
      q = {32'b0, num, 32'b0} / {64'b0, den};
      return q[63:0];
   endfunction

   function automatic longint fold_image(logic [63:0] a, logic [63:0] b, longint len);
      longint r;
      r = longint'(a) - longint'(b);
      if (2 * r < -len) r += len;
      else if (2 * r > len) r -= len;
      return r;
   endfunction

   function automatic longint clamp_add(longint acc, logic [63:0] mag, bit neg);
      longint s;
      if (mag > SAT48) mag = SAT48;
      s = neg ? acc - longint'(mag) : acc + longint'(mag);
      if (s > longint'(SAT48)) return longint'(SAT48);
      if (s < -longint'(SAT48) - 1) return -longint'(SAT48) - 1;
      return s;
   endfunction

   // Accumulate the energy and the force of one pair.
   task automatic add_pair(int i, int j);
      longint      d[3];
      logic [63:0] r2, s2, s6, s12, s12x2, mag, w, fr, ad, t;
      bit          eneg, fneg, dn, neg;
      d[0] = fold_image(pos_x_q[i], pos_x_q[j], longint'(lj_box));
      d[1] = fold_image(pos_y_q[i], pos_y_q[j], longint'(lj_box));
      d[2] = fold_image(pos_z_q[i], pos_z_q[j], longint'(lj_box));
      r2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
      if (r2 == 0 || r2 >= (lj_cut << 16)) return;
      s2  = div_scaled(lj_sigma * lj_sigma, r2);
      s6  = mul_scaled(mul_scaled(s2, s2, 32), s2, 32);
      s12 = mul_scaled(s6, s6, 32);
      eneg = s12 < s6;
      mag  = eneg ? s6 - s12 : s12 - s6;
      energy_sum = clamp_add(energy_sum, mul_scaled(mag, lj_eps * LJ_ENERGY_K, 32), eneg);
      s12x2 = s12[63] ? '1 : s12 << 1;
      fneg  = s12x2 < s6;
      mag   = fneg ? s6 - s12x2 : s12x2 - s6;
      w  = mul_scaled(mag, lj_eps * LJ_FORCE_K, 16);
      fr = div_scaled(w, r2);
      for (int k = 0; k < 3; k++) begin
         dn  = d[k] < 0;
         ad  = dn ? -d[k] : d[k];
         t   = mul_scaled(fr, ad, 32);
         neg = fneg != dn;
         case (k)
            0: begin
               frc_x[i] = clamp_add(frc_x[i], t, neg);
               frc_x[j] = clamp_add(frc_x[j], t, !neg);
            end
            1: begin
               frc_y[i] = clamp_add(frc_y[i], t, neg);
               frc_y[j] = clamp_add(frc_y[j], t, !neg);
            end
            default: begin
               frc_z[i] = clamp_add(frc_z[i], t, neg);
               frc_z[j] = clamp_add(frc_z[j], t, !neg);
            end
         endcase
      end
   endtask

   // Store one position; on the closing item evaluate the set and queue its results.
   task automatic predict_forces(req_type it, bit typed);
      rsp_type r;
      int      n;
      if (pos_x_q.size() < MAX_PARTICLES_DEF) begin
         pos_x_q.push_back(64'(it.pos_x));
         pos_y_q.push_back(64'(it.pos_y));
         pos_z_q.push_back(64'(it.pos_z));
      end
      if (!it.last) return;
      n = pos_x_q.size();
      energy_sum = 0;
      for (int i = 0; i < n; i++) begin
         frc_x[i] = 0;
         frc_y[i] = 0;
         frc_z[i] = 0;
      end
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            add_pair(i, j);
      for (int i = 0; i < n; i++) begin
         r.particle = i[PART_W-1:0];
         r.force_x  = frc_x[i][FORCE_W-1:0];
         r.force_y  = frc_y[i][FORCE_W-1:0];
         r.force_z  = frc_z[i][FORCE_W-1:0];
         r.energy   = (i == n - 1) ? energy_sum[FORCE_W-1:0] : '0;
         r.done_res = (i == n - 1);
         // A lone particle feels nothing and has no energy.
         if (typed) r = '{particle: '0, force_x: '0, force_y: '0, force_z: '0,
                          energy: '0, done_res: 1'b1};
         force_results_q.push_back(r);
      end
      pos_x_q.delete();
      pos_y_q.delete();
      pos_z_q.delete();
      sets_done++;
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Drive one particle and wait for its transfer.
   task automatic send_item(req_type it, bit typed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      predict_forces(it, typed);
      items_sent++;
   endtask

   task automatic send_pos(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit last,
                           bit typed);
      req_type it;
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      it.last  = last;
      send_item(it, typed);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SIGMA:   lj_sigma = 64'(value[23:0]);
         CSR_EPSILON: lj_eps   = 64'(value[23:0]);
         CSR_BOX:     lj_box   = 64'(value[23:0]);
         default:     lj_cut   = 64'(value);
      endcase
   endtask

   task automatic write_all(logic [31:0] s, logic [31:0] e, logic [31:0] b, logic [31:0] c);
      write_reg(CSR_SIGMA, s);
      write_reg(CSR_EPSILON, e);
      write_reg(CSR_BOX, b);
      write_reg(CSR_CUTOFF, c);
   endtask

   // Let every queued result drain, then give the core time to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (force_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [23:0] wrap_coord(longint v);
      longint b;
      b = (lj_box == 0) ? 1 : longint'(lj_box);
      v = v % b;
      if (v < 0) v += b;
      return v[23:0];
   endfunction

   // One random set: mostly clustered so that pairs fall inside the cutoff.
   task automatic send_random_set(int n);
      int          mode;
      longint      bx, by, bz, spread;
      logic [23:0] x, y, z;
      mode   = $urandom_range(0, 99);
      bx     = $urandom_range(0, 24'hFFFFFF);
      by     = $urandom_range(0, 24'hFFFFFF);
      bz     = $urandom_range(0, 24'hFFFFFF);
      spread = $urandom_range(16384, 196608);
      for (int i = 0; i < n; i++) begin
         if (mode < 70) begin
            x = wrap_coord(bx + $urandom_range(0, 2 * spread) - spread);
            y = wrap_coord(by + $urandom_range(0, 2 * spread) - spread);
            z = wrap_coord(bz + $urandom_range(0, 2 * spread) - spread);
         end else if (mode < 85) begin
            x = wrap_coord($urandom());
            y = wrap_coord($urandom());
            z = wrap_coord($urandom());
         end else begin
            x = 24'($urandom());
            y = 24'($urandom());
            z = 24'($urandom());
         end
         send_pos(x, y, z, i == n - 1, 1'b0);
      end
   endtask

   task automatic random_phase(int items);
      int sent, n, r;
      sent = 0;
      quiet = ($urandom_range(0, 3) == 0);
      while (sent < items) begin
         r = $urandom_range(0, 99);
         n = (r < 10) ? 1 : (r < 90) ? $urandom_range(2, 6) : $urandom_range(8, 14);
         send_random_set(n);
         sent += n;
      end
      drain();
   endtask

   // Result checker: compare each transfer against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (force_results_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %p", rsp_data);
         end else begin
            want = force_results_q.pop_front();
            if (rsp_data.particle !== want.particle || rsp_data.force_x !== want.force_x ||
                rsp_data.force_y !== want.force_y || rsp_data.force_z !== want.force_z ||
                rsp_data.energy !== want.energy || rsp_data.done_res !== want.done_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                           want, rsp_data);
            end
         end
      end
   end

   // Receiver back-pressure in random stretches.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall  <= !quiet && ($urandom_range(0, 2) == 0);
         stall_left = pick_gap();
      end
   end

   // Directed stimulus table.
   typedef struct {
      req_type it;
      bit      typed;
   } dir_row_type;
   dir_row_type dir_rows[$];

   task automatic add_row(logic [23:0] x, logic [23:0] y, logic [23:0] z, bit last,
                          bit typed);
      dir_row_type row;
      row.it.pos_x = x;
      row.it.pos_y = y;
      row.it.pos_z = z;
      row.it.last  = last;
      row.typed    = typed;
      dir_rows.push_back(row);
   endtask

   initial begin
      lj_sigma = 64'd65536;
      lj_eps   = 64'd65536;
      lj_box   = 64'd655360;
      lj_cut   = 64'd409600;
      // Single particles at both ends of the coordinate range.
      add_row(24'h0, 24'h0, 24'h0, 1'b1, 1'b1);
      add_row(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1);
      // Coincident pair.
      add_row(24'h012345, 24'h023456, 24'h034567, 1'b0, 1'b0);
      add_row(24'h012345, 24'h023456, 24'h034567, 1'b1, 1'b0);
      // Pair one unit apart, then a pair close only across the periodic boundary.
      add_row(24'h020000, 24'h020000, 24'h020000, 1'b0, 1'b0);
      add_row(24'h030000, 24'h020000, 24'h020000, 1'b1, 1'b0);
      add_row(24'h008000, 24'h098000, 24'h010000, 1'b0, 1'b0);
      add_row(24'h098000, 24'h008000, 24'h010000, 1'b1, 1'b0);
      // Separation of exactly half the box is not folded.
      add_row(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
      add_row(24'h050000, 24'h0, 24'h0, 1'b1, 1'b0);
      // Very close pair drives the repulsion into saturation.
      add_row(24'h010000, 24'h010000, 24'h010000, 1'b0, 1'b0);
      add_row(24'h010001, 24'h010000, 24'h010000, 1'b1, 1'b0);
      // Triple with coordinates at and beyond the box edge.
      add_row(24'h0A0000, 24'h09FFFF, 24'h0, 1'b0, 1'b0);
      add_row(24'hFFFFFF, 24'h0A0000, 24'h0, 1'b0, 1'b0);
      add_row(24'h09C000, 24'h000001, 24'hFFFFFF, 1'b1, 1'b0);
      // Pair just beyond the cutoff radius.
      add_row(24'h0, 24'h0, 24'h0, 1'b0, 1'b0);
      add_row(24'h028001, 24'h0, 24'h0, 1'b1, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed);
      drain();

      random_phase(40);
      write_all(32'h00C000, 32'h018000, 32'h080000, 32'h00090000);
      random_phase(35);
      // Extreme settings: largest values everywhere.
      write_all(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF);
      random_phase(25);
      // Extreme settings: smallest values, with the box edge at 1.
      write_all(32'h0, 32'h0, 32'h1, 32'h0);
      random_phase(20);
      write_all(32'h010000, 32'h010000, 32'h0A0000, 32'h0);
      random_phase(15);
      write_all($urandom_range(24'h8000, 24'h20000), $urandom_range(24'h4000, 24'h40000),
                $urandom_range(24'h40000, 24'h140000), $urandom_range(32'h10000, 32'hA0000));
      random_phase(40);
      write_all(32'h010000, 32'h010000, 32'h0A0000, 32'h64000);
      random_phase(45);

      // Overfilled store: two dropped positions, the second closing the set.
      quiet = 1'b0;
      for (int i = 0; i < MAX_PARTICLES_DEF + 2; i++)
         send_pos(wrap_coord($urandom()), wrap_coord($urandom()), wrap_coord($urandom()),
                  i == MAX_PARTICLES_DEF + 1, 1'b0);
      drain();

      $display("Covered %0d particle transfers in %0d sets, %0d results checked,",
               items_sent, sets_done, results_seen);
      $display("over seven register settings including both extremes.");
      if (mismatches == 0 && force_results_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, force_results_q.size());
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hung core.
   initial begin
      #100ms;
      $display("Timeout with %0d results outstanding", force_results_q.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
